// ----- rtl/lfu_pkg.sv -----
// Shared types for the LFU key-value cache.
// No dependencies; imported by the controller, datapath and top level.
package lfu_pkg;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned STAMP_W = 48;
  localparam int unsigned CAP_W   = 5;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic {KIND_LOOKUP = 1'b0, KIND_STORE = 1'b1} kind_e;

  // controller -> datapath
  typedef struct packed {
    logic load;     // latch the input item, clear scan state
    logic scan;     // examine entry at the scan index
    logic commit;   // apply the write-back chosen by the scan
  } lfu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last; // scan index is at the final entry
  } lfu_sts_t;
endpackage

// ----- rtl/lfu_ctrl.sv -----
// Sequencer for the LFU cache: load, scan each entry, commit, output.
// Depends on lfu_pkg.
module lfu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  lfu_pkg::lfu_sts_t sts_i,
  output lfu_pkg::lfu_cmd_t cmd_o
);
  import lfu_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT} state_e;
  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load   = in_valid_i && in_ready_o;
    cmd_o.scan   = (state_q == S_SCAN);
    cmd_o.commit = (state_q == S_COMMIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_valid_i && in_ready_o) state_q <= S_SCAN;
        S_SCAN: if (sts_i.scan_last) state_q <= S_COMMIT;
        S_COMMIT: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/lfu_dp.sv -----
// Datapath for the LFU cache: entry storage, serial scan, write-back.
// Depends on lfu_pkg.
module lfu_dp #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [lfu_pkg::CAP_W-1:0]   cfg_data_i,
  input  logic                        kind_i,
  input  logic [lfu_pkg::KEY_W-1:0]   key_i,
  input  logic [lfu_pkg::VAL_W-1:0]   value_i,
  input  lfu_pkg::lfu_cmd_t           cmd_i,
  output lfu_pkg::lfu_sts_t           sts_o,
  output logic                        found_o,
  output logic [lfu_pkg::VAL_W-1:0]   read_value_o
);
  import lfu_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);

  logic [ENTRIES-1:0] valid_q;
  logic [KEY_W-1:0]   key_mem   [ENTRIES];
  logic [VAL_W-1:0]   val_mem   [ENTRIES];
  logic [CNT_W-1:0]   cnt_mem   [ENTRIES];
  logic [STAMP_W-1:0] stamp_mem [ENTRIES];

  logic [CAP_W-1:0]   cap_q;
  logic [STAMP_W-1:0] clock_q;
  logic [OCC_W-1:0]   occ_q;

  logic               kind_q;
  logic [KEY_W-1:0]   key_q;
  logic [VAL_W-1:0]   val_q;
  logic [IDX_W-1:0]   idx_q;
  logic               hit_q, vic_ok_q, free_ok_q;
  logic [IDX_W-1:0]   hit_idx_q, vic_idx_q, free_idx_q;
  logic [CNT_W-1:0]   vic_cnt_q;
  logic [STAMP_W-1:0] vic_stamp_q;
  logic [CNT_W-1:0]   hit_cnt_q;
  logic               found_q;
  logic [VAL_W-1:0]   rd_q;

  // effective capacity, saturated to the table size
  logic [OCC_W:0] cap_eff;
  always_comb begin
    if ({{(OCC_W+1){1'b0}}, cap_q} > (OCC_W+1+CAP_W)'(ENTRIES))
      cap_eff = (OCC_W+1)'(ENTRIES);
    else
      cap_eff = (OCC_W+1)'(cap_q);
  end

  logic disabled;
  assign disabled        = (cap_q == '0);
  assign sts_o.scan_last = (idx_q == IDX_W'(ENTRIES - 1));

  // current scanned entry
  logic               e_v;
  logic [KEY_W-1:0]   e_key;
  logic [CNT_W-1:0]   e_cnt;
  logic [STAMP_W-1:0] e_stamp;
  assign e_v     = valid_q[idx_q];
  assign e_key   = key_mem[idx_q];
  assign e_cnt   = cnt_mem[idx_q];
  assign e_stamp = stamp_mem[idx_q];

  logic better;
  assign better = !vic_ok_q || (e_cnt < vic_cnt_q) ||
                  ((e_cnt == vic_cnt_q) && (e_stamp < vic_stamp_q));

  logic [STAMP_W-1:0] clock_inc;
  assign clock_inc = clock_q + STAMP_W'(1);
  logic full;
  assign full = ({1'b0, occ_q} >= cap_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cap_q   <= CAP_W'(16);
      clock_q <= '0;
      occ_q   <= '0;
      idx_q   <= '0;
    end else begin
      if (cfg_valid_i) cap_q <= cfg_data_i;
      if (cmd_i.load) idx_q <= '0;
      else if (cmd_i.scan && !sts_o.scan_last) idx_q <= idx_q + IDX_W'(1);
      if (cmd_i.commit && !disabled) begin
        if (hit_q) begin
          clock_q <= clock_inc;
        end else if (kind_q == KIND_STORE) begin
          if (full && vic_ok_q) begin
            clock_q <= clock_inc;
          end else if (free_ok_q) begin
            valid_q[free_idx_q] <= 1'b1;
            occ_q   <= occ_q + OCC_W'(1);
            clock_q <= clock_inc;
          end
        end
      end
    end
  end

  // item latch, scan accumulators and memory writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q    <= kind_i;
      key_q     <= key_i;
      val_q     <= value_i;
      hit_q     <= 1'b0;
      vic_ok_q  <= 1'b0;
      free_ok_q <= 1'b0;
    end
    if (cmd_i.scan) begin
      if (e_v && e_key == key_q && !hit_q) begin
        hit_q     <= 1'b1;
        hit_idx_q <= idx_q;
        hit_cnt_q <= e_cnt;
      end
      if (e_v && better) begin
        vic_ok_q    <= 1'b1;
        vic_idx_q   <= idx_q;
        vic_cnt_q   <= e_cnt;
        vic_stamp_q <= e_stamp;
      end
      if (!e_v && !free_ok_q) begin
        free_ok_q  <= 1'b1;
        free_idx_q <= idx_q;
      end
    end
    if (cmd_i.commit) begin
      found_q <= 1'b0;
      rd_q    <= '0;
      if (!disabled) begin
        if (hit_q) begin
          found_q <= 1'b1;
          if (hit_cnt_q != COUNT_MAX) cnt_mem[hit_idx_q] <= hit_cnt_q + CNT_W'(1);
          stamp_mem[hit_idx_q] <= clock_inc;
          if (kind_q == KIND_STORE) begin
            val_mem[hit_idx_q] <= val_q;
            rd_q <= val_q;
          end else begin
            rd_q <= val_mem[hit_idx_q];
          end
        end else if (kind_q == KIND_STORE) begin
          if (full && vic_ok_q) begin
            key_mem[vic_idx_q]   <= key_q;
            val_mem[vic_idx_q]   <= val_q;
            cnt_mem[vic_idx_q]   <= CNT_W'(1);
            stamp_mem[vic_idx_q] <= clock_inc;
          end else if (free_ok_q) begin
            key_mem[free_idx_q]   <= key_q;
            val_mem[free_idx_q]   <= val_q;
            cnt_mem[free_idx_q]   <= CNT_W'(1);
            stamp_mem[free_idx_q] <= clock_inc;
          end
        end
      end
    end
  end

  assign found_o      = found_q;
  assign read_value_o = rd_q;
endmodule

// ----- rtl/lfu_key_value_cache.sv -----
// Top level of the LFU key-value cache.
// Depends on lfu_pkg, lfu_ctrl and lfu_dp.
//
// Usage:
//  - s_axis: one item per request. tdata = {value[63:32], key[31:0]},
//    tuser = kind (0 lookup, 1 store).
//  - m_axis: one result per request. tdata = read_value, tuser = found.
//  - cfg: capacity_in_use write (5 bits), taken whenever cfg_valid_i is
//    high; write only while idle.
// Sequence: an accept edge, a scan of every entry in turn (one entry per
// cycle through the shared compare unit), then a commit state; the result
// sits in the output register.
// Input reopens the cycle after the result is taken; one item in flight
// at a time.
// Stall: a held result blocks new input until m_axis_tready takes it.
// Reset: all entries invalid, capacity 16, access clock and occupancy
// zero; no clearing pass, the block is ready right after reset.
module lfu_key_value_cache #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // key[31:0], value[63:32]
  input  logic        s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // read_value[31:0]
  output logic        m_axis_tuser,  // found
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);
  import lfu_pkg::*;

  lfu_cmd_t cmd;
  lfu_sts_t sts;

  assign cfg_ready_o = 1'b1;

  lfu_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lfu_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk_i, .rst_ni,
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .kind_i       (s_axis_tuser),
    .key_i        (s_axis_tdata[31:0]),
    .value_i      (s_axis_tdata[63:32]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .found_o      (m_axis_tuser),
    .read_value_o (m_axis_tdata)
  );
endmodule
